// ----- src/asr_pkg.sv -----
`timescale 1ns / 1ps
// Package for the stereo resampler: widths, reset values, codes and the
// types shared by the front, the queue and the back. No dependencies.
package asr_pkg;

  localparam int RING_SAMPLES_DEF   = 16384;
  localparam int INTEGRAL_LIMIT_DEF = 4095;

  localparam int KIND_W     = 3;
  localparam int SAMPLE_W   = 16;
  localparam int INDEX_W    = 14;
  localparam int CFG_W      = 16;
  localparam int PHASE_W    = 18;
  localparam int PROP_W     = 10;
  localparam int RATE_W     = 17;
  localparam int RSUM_W     = RATE_W + 2;
  localparam int DVD_W      = 36;
  localparam int NUM_W      = DVD_W + 1;

  localparam logic [CFG_W-1:0] INPUT_RATE_RST  = 16'd44100;
  localparam logic [CFG_W-1:0] OUTPUT_RATE_RST = 16'd48000;

  localparam logic CFG_INPUT_RATE  = 1'b0;
  localparam logic CFG_OUTPUT_RATE = 1'b1;

  typedef enum logic [KIND_W-1:0] {
    KIND_FRAME   = 3'd0,
    KIND_WRAP    = 3'd1,
    KIND_CHUNK   = 3'd2,
    KIND_SUSPEND = 3'd3,
    KIND_RESUME  = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    MODE_PAUSED,
    MODE_PREPARE,
    MODE_RESUMING,
    MODE_PLAYING
  } mode_t;

  typedef enum logic [1:0] {
    OP_FRAME,
    OP_WRAP,
    OP_CHUNK,
    OP_RESUME
  } op_code_t;

  typedef struct packed {
    op_code_t                    code;
    logic signed [SAMPLE_W-1:0]  left;
    logic signed [SAMPLE_W-1:0]  right;
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_SUM,
    ST_DIV,
    ST_EMIT
  } back_state_t;

endpackage

// ----- src/asr_if.sv -----
`timescale 1ns / 1ps
// Valid/ready channels of the resampler: input items and ring writes.
// Depends on asr_pkg for field widths.
interface asr_item_if;
  logic                                 valid;
  logic                                 ready;
  logic [asr_pkg::KIND_W-1:0]           kind;
  logic signed [asr_pkg::SAMPLE_W-1:0]  left_in;
  logic signed [asr_pkg::SAMPLE_W-1:0]  right_in;
  modport source (output valid, kind, left_in, right_in, input ready);
  modport sink (input valid, kind, left_in, right_in, output ready);
endinterface

interface asr_result_if;
  logic                                 valid;
  logic                                 ready;
  logic [asr_pkg::INDEX_W-1:0]          write_index;
  logic signed [asr_pkg::SAMPLE_W-1:0]  left_out;
  logic signed [asr_pkg::SAMPLE_W-1:0]  right_out;
  logic                                 last;
  modport source (output valid, write_index, left_out, right_out, last, input ready);
  modport sink (input valid, write_index, left_out, right_out, last, output ready);
endinterface

// ----- src/adaptive_stereo_resampler.sv -----
`timescale 1ns / 1ps
// Stereo linear-interpolation resampler, top level. Depends on asr_pkg,
// asr_if, asr_front, asr_queue, asr_back and asr_div.
// A frame that leaves the queue passes multiply, sum, serial divide and the
// output load before its first ring write; a second write, when the phase
// allows one, repeats those steps. The back takes control items in its idle
// state. Synchronous reset clears mode, offset, error, trims, phase and
// history; rates return to 44100 and 48000.
module adaptive_stereo_resampler #(
  parameter int RING_SAMPLES   = asr_pkg::RING_SAMPLES_DEF,
  parameter int INTEGRAL_LIMIT = asr_pkg::INTEGRAL_LIMIT_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [asr_pkg::CFG_W-1:0]  cfg_data,
  asr_item_if.sink                   item,
  asr_result_if.source               result
);
  import asr_pkg::*;

  logic [CFG_W-1:0] input_rate;
  logic [CFG_W-1:0] output_rate_nominal;

  logic push, full, pop_valid, pop;
  op_t  push_op, pop_op;

  always_ff @(posedge clk) begin
    if (rst) begin
      input_rate          <= INPUT_RATE_RST;
      output_rate_nominal <= OUTPUT_RATE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_INPUT_RATE:  input_rate <= cfg_data;
        CFG_OUTPUT_RATE: output_rate_nominal <= cfg_data;
        default: ;
      endcase
    end
  end

  asr_front u_front (
    .clk, .rst, .item, .push, .push_op, .full
  );

  asr_queue u_queue (
    .clk, .rst, .push, .push_op, .full, .pop_valid, .pop_op, .pop
  );

  asr_back #(
    .RING_SAMPLES(RING_SAMPLES), .INTEGRAL_LIMIT(INTEGRAL_LIMIT)
  ) u_back (
    .clk, .rst, .op_valid(pop_valid), .op(pop_op), .op_ready(pop),
    .input_rate, .output_rate_nominal, .result
  );

endmodule

// ----- src/asr_div.sv -----
`timescale 1ns / 1ps
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on nothing but its parameters.
module asr_div #(
  parameter int DVD_W = 36,
  parameter int DVS_W = 17
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic [DVD_W-1:0] quotient,
  output logic             done
);
  localparam int CNT_W = $clog2(DVD_W + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DVS_W-1:0] rem;
  logic [DVS_W-1:0] dvs;
  logic [DVD_W-1:0] quo;
  logic [DVS_W:0]   trial;
  logic             ge;
  logic [DVS_W:0]   diff;

  assign trial    = {rem, quo[DVD_W-1]};
  assign ge       = trial >= {1'b0, dvs};
  assign diff     = trial - {1'b0, dvs};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DVD_W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dvs <= divisor;
      quo <= dividend;
    end else if (busy) begin
      // remainder stays below the divisor, so the top bit drops
      rem <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
      quo <= {quo[DVD_W-2:0], ge};
    end
  end

endmodule

// ----- src/asr_front.sv -----
`timescale 1ns / 1ps
// Front of the resampler: accepts items, tracks the play mode and queues
// the operations that touch the datapath. Depends on asr_pkg and asr_if.
module asr_front (
  input  logic           clk,
  input  logic           rst,
  asr_item_if.sink       item,
  output logic           push,
  output asr_pkg::op_t   push_op,
  input  logic           full
);
  import asr_pkg::*;

  mode_t mode, mode_next;
  logic  take;

  assign item.ready = !full;
  assign take       = item.valid && item.ready;

  always_comb begin
    mode_next     = mode;
    push          = 1'b0;
    push_op.code  = OP_FRAME;
    push_op.left  = item.left_in;
    push_op.right = item.right_in;
    if (take) begin
      unique case (item.kind)
        KIND_FRAME: push = (mode == MODE_PLAYING);
        KIND_WRAP: begin
          push         = 1'b1;
          push_op.code = OP_WRAP;
          if (mode == MODE_RESUMING) mode_next = MODE_PLAYING;
        end
        KIND_CHUNK: begin
          push_op.code = OP_CHUNK;
          // drop the first chunk after a resume
          if (mode == MODE_PREPARE) mode_next = MODE_RESUMING;
          else push = (mode == MODE_PLAYING);
        end
        KIND_SUSPEND: mode_next = MODE_PAUSED;
        KIND_RESUME: begin
          push_op.code = OP_RESUME;
          if (mode == MODE_PAUSED) begin
            push      = 1'b1;
            mode_next = MODE_PREPARE;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) mode <= MODE_PAUSED;
    else mode <= mode_next;
  end

endmodule

// ----- src/asr_queue.sv -----
`timescale 1ns / 1ps
// Two-entry queue of operations between front and back.
// Depends on asr_pkg.
module asr_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  asr_pkg::op_t  push_op,
  output logic          full,
  output logic          pop_valid,
  output asr_pkg::op_t  pop_op,
  input  logic          pop
);
  import asr_pkg::*;

  op_t        entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_pop;

  assign full      = count == 2'd2;
  assign pop_valid = count != 2'd0;
  assign pop_op    = entry[rd_ptr];
  // a pop only counts when a word is there
  assign do_pop    = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (do_pop) rd_ptr <= !rd_ptr;
      unique case ({push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) entry[wr_ptr] <= push_op;
  end

endmodule

// ----- src/asr_back.sv -----
`timescale 1ns / 1ps
// Back of the resampler: ring position, fill error, rate trims, phase,
// interpolation through serial dividers, and the output register.
// Depends on asr_pkg, asr_if and asr_div.
module asr_back #(
  parameter int RING_SAMPLES   = asr_pkg::RING_SAMPLES_DEF,
  parameter int INTEGRAL_LIMIT = asr_pkg::INTEGRAL_LIMIT_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        op_valid,
  input  asr_pkg::op_t                op,
  output logic                        op_ready,
  input  logic [asr_pkg::CFG_W-1:0]   input_rate,
  input  logic [asr_pkg::CFG_W-1:0]   output_rate_nominal,
  asr_result_if.source                result
);
  import asr_pkg::*;

  localparam int OFF_W    = $clog2(RING_SAMPLES);
  localparam int FE_W     = OFF_W + 2;
  localparam int INT_W    = $clog2(INTEGRAL_LIMIT + 1) + 1;
  localparam int HALF     = RING_SAMPLES / 2;
  localparam int QUARTER  = RING_SAMPLES / 4;
  localparam int PROP_DIV = RING_SAMPLES / 256;
  localparam int PROP_SH  = $clog2(PROP_DIV);

  back_state_t state, state_next;

  logic [OFF_W-1:0]              write_offset;
  logic signed [FE_W-1:0]        fill_error;
  logic signed [1:0]             error_side;
  logic signed [INT_W-1:0]       trim_integral;
  logic signed [PROP_W-1:0]      trim_prop;
  logic signed [PHASE_W-1:0]     phase;
  logic signed [SAMPLE_W-1:0]    prev_l, prev_r, cur_l, cur_r;
  logic [RATE_W-1:0]             rate_r;
  logic                          second;
  logic signed [33:0]            pn_l, pn_r;
  logic signed [34:0]            pb_l, pb_r;
  logic                          neg_l, neg_r;

  logic                          out_valid;
  logic [INDEX_W-1:0]            out_index;
  logic signed [SAMPLE_W-1:0]    out_l, out_r;
  logic                          out_last;

  // combinational helpers
  logic signed [RSUM_W-1:0]      rsum;
  logic [RATE_W-1:0]             rate_sat;
  logic signed [RSUM_W-1:0]      diff;
  logic signed [NUM_W-1:0]       num_l, num_r, mag_l, mag_r;
  logic signed [FE_W-1:0]        s0;
  logic signed [FE_W-1:0]        fe_abs;
  logic [FE_W-1:0]               prop_mag;
  logic [OFF_W:0]                off_inc;
  logic signed [PHASE_W-1:0]     p1;
  logic                          again;
  logic                          out_free;
  logic                          out_load;
  logic [SAMPLE_W-1:0]           ql, qr;
  logic signed [PROP_W-1:0]      prop_val;

  logic                          div_start;
  logic [DVD_W-1:0]              dvd_l, dvd_r;
  logic [RATE_W-1:0]             dvs;
  logic [DVD_W-1:0]              quo_l, quo_r;
  logic                          done_l, done_r;

  assign rsum = $signed({{(RSUM_W-CFG_W){1'b0}}, output_rate_nominal})
              + RSUM_W'(trim_integral) + RSUM_W'(trim_prop);
  assign rate_sat = (rsum < $signed(RSUM_W'(1))) ? RATE_W'(1) : rsum[RATE_W-1:0];

  assign diff  = $signed({2'b00, rate_r}) - RSUM_W'(phase);
  assign num_l = NUM_W'(pn_l) + NUM_W'(pb_l);
  assign num_r = NUM_W'(pn_r) + NUM_W'(pb_r);
  assign mag_l = num_l[NUM_W-1] ? -num_l : num_l;
  assign mag_r = num_r[NUM_W-1] ? -num_r : num_r;

  assign s0       = $signed({2'b00, write_offset}) - FE_W'(HALF);
  assign fe_abs   = fill_error[FE_W-1] ? -fill_error : fill_error;
  assign prop_mag = $unsigned(fe_abs) >> PROP_SH;
  assign off_inc  = {1'b0, write_offset} + (OFF_W+1)'(2);
  assign p1       = phase + $signed({{(PHASE_W-CFG_W){1'b0}}, input_rate});
  assign again    = !second && ($signed({p1[PHASE_W-1], p1}) < $signed({2'b00, rate_r}));
  assign out_free = !out_valid || result.ready;
  assign out_load = (state == ST_EMIT) && out_free;
  assign ql       = quo_l[SAMPLE_W-1:0];
  assign qr       = quo_r[SAMPLE_W-1:0];
  // error over the divisor, negated, truncated toward zero
  assign prop_val = fill_error[FE_W-1] ? $signed(prop_mag[PROP_W-1:0])
                                       : -$signed(prop_mag[PROP_W-1:0]);

  assign dvd_l = mag_l[DVD_W-1:0];
  assign dvd_r = mag_r[DVD_W-1:0];
  assign dvs   = rate_r;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (op_valid) begin
          unique case (op.code)
            OP_FRAME: state_next = ST_MUL;
            default:  state_next = ST_IDLE;
          endcase
        end
      end
      ST_MUL:  state_next = ST_SUM;
      ST_SUM:  state_next = ST_DIV;
      ST_DIV:  if (done_l) state_next = ST_EMIT;
      ST_EMIT: if (out_free) state_next = again ? ST_MUL : ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    op_ready  = (state == ST_IDLE);
    div_start = (state == ST_SUM);
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_offset  <= '0;
      fill_error    <= '0;
      error_side    <= '0;
      trim_integral <= '0;
      trim_prop     <= '0;
      phase         <= '0;
      prev_l        <= '0;
      prev_r        <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (out_load) out_valid <= 1'b1;
      else if (result.ready) out_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (op_valid) begin
            unique case (op.code)
              OP_FRAME: begin
                cur_l  <= op.left;
                cur_r  <= op.right;
                rate_r <= rate_sat;
                second <= 1'b0;
              end
              OP_WRAP: begin
                if (s0 < 0 && s0 > FE_W'(-QUARTER)) begin
                  error_side <= -2'sd1;
                  fill_error <= s0;
                end else if (s0 >= 0 && s0 < FE_W'(QUARTER)) begin
                  error_side <= 2'sd1;
                  fill_error <= s0;
                end else if (error_side > 0 && s0 < 0) begin
                  fill_error <= s0 + FE_W'(RING_SAMPLES);
                end else if (s0 > 0) begin
                  fill_error <= s0 - FE_W'(RING_SAMPLES);
                end else begin
                  fill_error <= s0;
                end
              end
              OP_CHUNK: begin
                if (fill_error != '0) begin
                  trim_prop  <= prop_val;
                  fill_error <= '0;
                  if (prop_val > 0 && trim_integral < INT_W'(INTEGRAL_LIMIT))
                    trim_integral <= trim_integral + INT_W'(1);
                  if (prop_val < 0 && trim_integral > INT_W'(-INTEGRAL_LIMIT))
                    trim_integral <= trim_integral - INT_W'(1);
                end
              end
              OP_RESUME: begin
                write_offset <= OFF_W'(HALF);
                fill_error   <= '0;
                phase        <= '0;
                prev_l       <= '0;
                prev_r       <= '0;
              end
              default: ;
            endcase
          end
        end
        ST_MUL: begin
          pn_l <= phase * cur_l;
          pn_r <= phase * cur_r;
          pb_l <= diff * prev_l;
          pb_r <= diff * prev_r;
        end
        ST_SUM: begin
          neg_l <= num_l[NUM_W-1];
          neg_r <= num_r[NUM_W-1];
        end
        ST_EMIT: begin
          if (out_free) begin
            out_index    <= INDEX_W'(write_offset);
            out_l        <= neg_l ? -ql : ql;
            out_r        <= neg_r ? -qr : qr;
            out_last     <= !again;
            write_offset <= (off_inc >= (OFF_W+1)'(RING_SAMPLES)) ? '0 : off_inc[OFF_W-1:0];
            if (again) begin
              phase  <= p1;
              second <= 1'b1;
            end else begin
              phase  <= p1 - $signed({1'b0, rate_r});
              prev_l <= cur_l;
              prev_r <= cur_r;
            end
          end
        end
        default: ;
      endcase
    end
  end

  asr_div #(.DVD_W(DVD_W), .DVS_W(RATE_W)) u_div_l (
    .clk, .rst, .start(div_start), .dividend(dvd_l), .divisor(dvs),
    .quotient(quo_l), .done(done_l)
  );

  asr_div #(.DVD_W(DVD_W), .DVS_W(RATE_W)) u_div_r (
    .clk, .rst, .start(div_start), .dividend(dvd_r), .divisor(dvs),
    .quotient(quo_r), .done(done_r)
  );

  assign result.valid       = out_valid;
  assign result.write_index = out_index;
  assign result.left_out    = out_l;
  assign result.right_out   = out_r;
  assign result.last        = out_last;

  a_offset_even: assert property (@(posedge clk) disable iff (rst)
    !write_offset[0] && (OFF_W+1)'(write_offset) < (OFF_W+1)'(RING_SAMPLES))
    else $error("ring offset odd or past the ring");

  a_integral_bound: assert property (@(posedge clk) disable iff (rst)
    trim_integral <= INT_W'(INTEGRAL_LIMIT) && trim_integral >= INT_W'(-INTEGRAL_LIMIT))
    else $error("integral trim out of bounds");

  a_rate_positive: assert property (@(posedge clk) disable iff (rst)
    state == ST_MUL |-> rate_r != '0)
    else $error("zero rate in interpolation");

  a_lanes_lockstep: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV |-> done_l == done_r)
    else $error("divider lanes out of step");

endmodule

// ----- tb/sv/adaptive_stereo_resampler_tb.sv -----
`timescale 1ns / 1ps
// Self-checking bench for adaptive_stereo_resampler: drives frames and control
// items, predicts every ring write and compares it. Depends on asr_pkg, asr_if.
module adaptive_stereo_resampler_tb;
  import asr_pkg::*;

  localparam int RING     = RING_SAMPLES_DEF;
  localparam int I_LIMIT  = INTEGRAL_LIMIT_DEF;
  localparam int SETTLE   = 250;
  localparam int MAX_CYC  = 3000000;
  localparam int HOLD_CYC = 3000;

  typedef struct {
    logic [INDEX_W-1:0]         idx;
    logic signed [SAMPLE_W-1:0] left;
    logic signed [SAMPLE_W-1:0] right;
    logic                       last;
  } ring_write_t;

  class resampler_scoreboard;
    int unsigned              in_rate;
    int unsigned              out_rate;
    mode_t                    mode;
    int                       offset;
    int                       fill_err;
    int                       err_side;
    int                       trim_int;
    int                       trim_prop;
    logic signed [PHASE_W-1:0] phase;
    logic signed [SAMPLE_W-1:0] prev_l;
    logic signed [SAMPLE_W-1:0] prev_r;
    ring_write_t              writes_q[$];
    int                       mismatches;

    function new();
      in_rate    = INPUT_RATE_RST;
      out_rate   = OUTPUT_RATE_RST;
      mode       = MODE_PAUSED;
      offset     = 0;
      fill_err   = 0;
      err_side   = 0;
      trim_int   = 0;
      trim_prop  = 0;
      phase      = '0;
      prev_l     = '0;
      prev_r     = '0;
      mismatches = 0;
    endfunction

    function void set_rate(logic idx, logic [CFG_W-1:0] val);
      if (idx == CFG_INPUT_RATE) in_rate = val;
      else out_rate = val;
    endfunction

    function logic [SAMPLE_W-1:0] blend(longint rate, logic signed [SAMPLE_W-1:0] now,
                                        logic signed [SAMPLE_W-1:0] was);
      longint p;
      longint num;
      longint q;
      p   = longint'(phase);
      num = p * longint'(now) + (rate - p) * longint'(was);
      q   = num / rate;
      return q[SAMPLE_W-1:0];
    endfunction

    function void push_write(longint rate, logic signed [SAMPLE_W-1:0] l,
                             logic signed [SAMPLE_W-1:0] r);
      ring_write_t w;
      w.idx   = offset[INDEX_W-1:0];
      w.left  = blend(rate, l, prev_l);
      w.right = blend(rate, r, prev_r);
      w.last  = 1'b0;
      writes_q.push_back(w);
      offset += 2;
      if (offset >= RING) offset = 0;
    endfunction

    function void note_item(logic [KIND_W-1:0] kind, logic signed [SAMPLE_W-1:0] l,
                            logic signed [SAMPLE_W-1:0] r);
      longint rate;
      int     s;
      case (kind)
        KIND_FRAME: begin
          if (mode == MODE_PLAYING) begin
            rate = longint'(out_rate) + trim_int + trim_prop;
            if (rate < 1) rate = 1;
            push_write(rate, l, r);
            phase = longint'(phase) + in_rate;
            if (longint'(phase) < rate) begin
              push_write(rate, l, r);
              phase = longint'(phase) + in_rate;
            end
            phase  = longint'(phase) - rate;
            prev_l = l;
            prev_r = r;
            writes_q[$].last = 1'b1;
          end
        end
        KIND_WRAP: begin
          s = offset - RING / 2;
          if (s < 0 && s > -(RING / 4)) err_side = -1;
          else if (s >= 0 && s < RING / 4) err_side = 1;
          else if (err_side > 0 && s < 0) s += RING;
          else if (s > 0) s -= RING;
          fill_err = s;
          if (mode == MODE_RESUMING) mode = MODE_PLAYING;
        end
        KIND_CHUNK: begin
          if (mode == MODE_PREPARE) mode = MODE_RESUMING;
          else if (mode == MODE_PLAYING && fill_err != 0) begin
            trim_prop = -(fill_err / (RING / 256));
            if (trim_prop > 0 && trim_int < I_LIMIT) trim_int++;
            if (trim_prop < 0 && trim_int > -I_LIMIT) trim_int--;
            fill_err = 0;
          end
        end
        KIND_SUSPEND: mode = MODE_PAUSED;
        KIND_RESUME: begin
          if (mode == MODE_PAUSED) begin
            offset   = RING / 2;
            if (offset >= RING) offset = 0;
            fill_err = 0;
            phase    = '0;
            prev_l   = '0;
            prev_r   = '0;
            mode     = MODE_PREPARE;
          end
        end
        default: ;
      endcase
    endfunction

    function void check_write(ring_write_t got);
      ring_write_t exp_w;
      if (writes_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected ring write idx=%0d l=%0d r=%0d last=%0b",
                   got.idx, got.left, got.right, got.last);
        return;
      end
      exp_w = writes_q.pop_front();
      if (got.idx !== exp_w.idx || got.left !== exp_w.left ||
          got.right !== exp_w.right || got.last !== exp_w.last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ring write mismatch: exp idx=%0d l=%0d r=%0d last=%0b",
                   exp_w.idx, exp_w.left, exp_w.right, exp_w.last,
                   ", got idx=%0d l=%0d r=%0d last=%0b",
                   got.idx, got.left, got.right, got.last);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic cfg_index = 1'b0;
  logic [CFG_W-1:0] cfg_data = '0;

  asr_item_if   item_ch();
  asr_result_if result_ch();

  resampler_scoreboard sb = new();

  int  send_idle = 18;
  int  recv_idle = 65;
  logic hold_req = 1'b0;
  logic hold_on  = 1'b0;
  int  cycles = 0;

  adaptive_stereo_resampler i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item      (item_ch),
    .result    (result_ch)
  );

  always #10 clk = ~clk;

  initial begin
    item_ch.valid    = 1'b0;
    item_ch.kind     = '0;
    item_ch.left_in  = '0;
    item_ch.right_in = '0;
    result_ch.ready  = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > MAX_CYC) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Result side: check each accepted word, then pick the next ready.
  always @(posedge clk) begin
    ring_write_t w;
    if (!rst && result_ch.valid && result_ch.ready) begin
      w.idx   = result_ch.write_index;
      w.left  = result_ch.left_out;
      w.right = result_ch.right_out;
      w.last  = result_ch.last;
      sb.check_write(w);
    end
    if (hold_on) result_ch.ready <= 1'b0;
    else result_ch.ready <= ($urandom_range(99) >= recv_idle);
  end

  // Long receiver hold-off so the block backs up and stalls its input.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_on <= 1'b1;
        repeat (HOLD_CYC) @(posedge clk);
        hold_on  <= 1'b0;
        hold_req <= 1'b0;
        @(posedge clk);
      end
    end
  end

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(11))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'sh0000;
      3: return 16'shffff;
      default: return 16'($urandom);
    endcase
  endfunction

  // Called at a rising edge; returns at the edge where the word is taken.
  task automatic send_item(logic [KIND_W-1:0] kind, logic [SAMPLE_W-1:0] l = '0,
                           logic [SAMPLE_W-1:0] r = '0);
    while ($urandom_range(99) < send_idle) begin
      item_ch.valid <= 1'b0;
      @(posedge clk);
    end
    item_ch.valid    <= 1'b1;
    item_ch.kind     <= kind;
    item_ch.left_in  <= l;
    item_ch.right_in <= r;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    sb.note_item(kind, l, r);
  endtask

  task automatic send_frame();
    send_item(KIND_FRAME, pick_sample(), pick_sample());
  endtask

  task automatic drain();
    item_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.writes_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_rate(idx, val);
    @(posedge clk);
  endtask

  task automatic set_rates(logic [CFG_W-1:0] rin, logic [CFG_W-1:0] rout);
    drain();
    write_reg(CFG_INPUT_RATE, rin);
    write_reg(CFG_OUTPUT_RATE, rout);
  endtask

  // Well-formed session: resume, drop a chunk, wrap into playing, then mostly
  // frames with wraps and chunks; some noise and broken restarts.
  task automatic run_session(int frames);
    int k;
    send_item(KIND_RESUME);
    send_item(KIND_CHUNK);
    send_item(KIND_WRAP);
    for (int i = 0; i < frames; i++) begin
      k = $urandom_range(99);
      if (k < 84) send_frame();
      else if (k < 91) send_item(KIND_WRAP);
      else if (k < 97) send_item(KIND_CHUNK);
      else if (k < 98) send_item(kind_t'($urandom_range(7, 5)), 16'($urandom), 16'($urandom));
      else if (k < 99) send_item(KIND_RESUME);
      else begin
        send_item(KIND_SUSPEND);
        send_frame();
        send_item(KIND_RESUME);
        send_frame();
        send_item(KIND_CHUNK);
        send_item(KIND_WRAP);
      end
    end
    send_item(KIND_SUSPEND);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: control paths, sample extremes, dropped and unknown items.
    send_item(KIND_FRAME, 16'sh7fff, 16'sh8000);
    send_item(KIND_CHUNK);
    send_item(KIND_WRAP);
    send_item(KIND_RESUME);
    send_item(KIND_RESUME);
    send_item(KIND_FRAME, 16'sh1234, 16'sh4321);
    send_item(KIND_CHUNK);
    send_item(KIND_CHUNK);
    send_item(KIND_WRAP);
    send_item(KIND_FRAME, 16'sh7fff, 16'sh8000);
    send_item(KIND_FRAME, 16'sh8000, 16'sh7fff);
    send_item(KIND_FRAME, 16'sh0000, 16'shffff);
    send_item(KIND_FRAME, 16'shffff, 16'sh0000);
    send_item(KIND_CHUNK);
    send_item(KIND_WRAP);
    send_item(KIND_CHUNK);
    send_item(KIND_FRAME, 16'sh5555, 16'shaaaa);
    send_item(3'd5, 16'shffff, 16'shffff);
    send_item(3'd6);
    send_item(3'd7);
    send_item(KIND_SUSPEND);
    send_item(KIND_SUSPEND);
    send_item(KIND_FRAME, 16'sh7fff, 16'sh7fff);
    send_item(KIND_WRAP);

    run_session(200);
    set_rates(16'd30000, 16'd65535);
    hold_req <= 1'b1;
    run_session(200);

    send_idle = 65;
    recv_idle = 18;
    set_rates(16'd65535, 16'd1);
    run_session(150);
    set_rates(16'd65535, 16'd65535);
    run_session(120);
    set_rates(16'($urandom_range(40000, 1)), 16'($urandom_range(65535, 40001)));
    run_session(200);

    // Tiny input rate: two writes per frame and a phase that wraps.
    send_idle = 0;
    recv_idle = 0;
    set_rates(16'd1, 16'd65535);
    run_session(200);
    set_rates(INPUT_RATE_RST, OUTPUT_RATE_RST);
    run_session(100);

    drain();
    if (sb.mismatches == 0 && sb.writes_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

// ----- sim.f -----
src/asr_pkg.sv
src/asr_if.sv
src/asr_div.sv
src/asr_front.sv
src/asr_queue.sv
src/asr_back.sv
src/adaptive_stereo_resampler.sv
tb/sv/adaptive_stereo_resampler_tb.sv
